// ===== hdl/sfsc_pkg.sv =====
package sfsc_pkg;

  // Field widths
  localparam int VOLT_W    = 14;  // unsigned millivolt magnitudes
  localparam int FF_W      = 7;
  localparam int ERR_W     = 31;  // unsigned Q15.16 thresholds
  localparam int TICK_W    = 16;
  localparam int PID_W     = 18;
  localparam int IN_ERR_W  = 32;
  localparam int OUT_V_W   = 15;
  localparam int REASON_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 31;

  // Divider sizing: dividend 2*full*num + den, divisor 2*den, quotient <= full
  localparam int PROD_W    = VOLT_W + ERR_W;   // full * num
  localparam int DVD_W     = PROD_W + 2;       // 2*prod + den, with carry
  localparam int DVS_W     = ERR_W + 1;        // 2*den
  localparam int QUO_W     = VOLT_W;
  localparam int DCNT_W    = $clog2(QUO_W);

  localparam int NEAR_DIVISOR_DEF = 4;
  localparam int FLOOR_SCALE      = 100;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDFORWARD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPTABLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_MIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_MODE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE        = 3'd7;

  localparam logic [VOLT_W-1:0] MAX_VOLT_RST = 14'd12000;

  // Action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // End reasons
  localparam logic [REASON_W-1:0] REASON_RUNNING = 2'd0;
  localparam logic [REASON_W-1:0] REASON_SETTLED = 2'd1;
  localparam logic [REASON_W-1:0] REASON_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [VOLT_W-1:0] max_volt;
    logic [FF_W-1:0]   feedforward;
    logic [ERR_W-1:0]  acceptable_err;
    logic [ERR_W-1:0]  full_floor_err;
    logic [VOLT_W-1:0] near_min_volt;
    logic              turn_mode;
    logic [TICK_W-1:0] timeout_ticks;
    logic [TICK_W-1:0] settle_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

// ===== hdl/sfsc_if.sv =====
interface sfsc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic signed [sfsc_pkg::PID_W-1:0]     pid_command;
  logic signed [sfsc_pkg::IN_ERR_W-1:0]  error;

  modport source (output valid, action, pid_command, error, input ready);
  modport sink   (input valid, action, pid_command, error, output ready);
endinterface

interface sfsc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sfsc_pkg::OUT_V_W-1:0]   left_volt;
  logic signed [sfsc_pkg::OUT_V_W-1:0]   right_volt;
  logic                                  finished;
  logic [sfsc_pkg::REASON_W-1:0]         end_reason;

  modport source (output valid, left_volt, right_volt, finished, end_reason, input ready);
  modport sink   (input valid, left_volt, right_volt, finished, end_reason, output ready);
endinterface

// ===== hdl/stiction_floor_settle_controller.sv =====
// Flow: an accepted transaction is captured, evaluated and then loaded into the output register;
//   a tick that needs the tapered floor also passes the multiply, divider-start and divide states,
//   the serial 14-step divider setting the long path. The load waits until the output register is
//   free, and the input stays blocked until the result is loaded.
// Reset (synchronous, rst_n low): registers take their defaults, the move is idle and
//   finished, and the output register holds no result.
module stiction_floor_settle_controller #(
  parameter int NEAR_DIVISOR = sfsc_pkg::NEAR_DIVISOR_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sfsc_in_if.sink                         in_ch,
  sfsc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sfsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfsc_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  localparam int VW = sfsc_pkg::VOLT_W;
  localparam int SW = VW + 5;  // signed working width of the command

  // Near floor = full floor / NEAR_DIVISOR by reciprocal multiplication; exact for
  // every floor below 2**VW. The scale of 100 is folded into the constant so the
  // feedforward register feeds a single constant multiply.
  localparam int NEAR_SH     = VW + $clog2(NEAR_DIVISOR);
  localparam int NEAR_RECIP  = ((1 << NEAR_SH) + NEAR_DIVISOR - 1) / NEAR_DIVISOR;
  localparam int NEAR_MUL    = NEAR_RECIP * sfsc_pkg::FLOOR_SCALE;
  localparam int NEAR_PROD_W = sfsc_pkg::FF_W + VW + 8;

  sfsc_pkg::cfg_t   cfg;
  sfsc_pkg::state_t state_r, state_nxt;

  // Captured transaction
  logic                                action_r;
  logic signed [sfsc_pkg::PID_W-1:0]   pid_r;
  logic                                err_neg_r;
  logic [sfsc_pkg::IN_ERR_W-1:0]       aerr_r;

  // Floor datapath
  logic                                use_floor_r;
  logic [VW-1:0]                       applied_r;
  logic [VW-1:0]                       nearf_r;
  logic [VW-1:0]                       full_r;
  logic [sfsc_pkg::ERR_W-1:0]          num_r;
  logic [sfsc_pkg::ERR_W-1:0]          den_r;
  logic [sfsc_pkg::PROD_W-1:0]         prod_r;

  // Move state
  logic [sfsc_pkg::TICK_W-1:0]         elapsed_r;
  logic [sfsc_pkg::TICK_W-1:0]         settled_r;
  logic                                move_done_r;
  logic [sfsc_pkg::REASON_W-1:0]       reason_r;

  // Output register
  logic                                out_valid_r;
  logic signed [sfsc_pkg::OUT_V_W-1:0] left_r;
  logic signed [sfsc_pkg::OUT_V_W-1:0] right_r;
  logic                                finished_r;
  logic [sfsc_pkg::REASON_W-1:0]       end_reason_r;

  // Divider hookup
  logic                                div_start;
  logic                                div_done;
  logic [sfsc_pkg::QUO_W-1:0]          div_q;
  logic [sfsc_pkg::DVD_W-1:0]          div_dividend;
  logic [sfsc_pkg::DVS_W-1:0]          div_divisor;

  // Evaluation-cycle terms
  logic [VW-1:0]                       full_w;
  logic [NEAR_PROD_W-1:0]              near_prod_w;
  logic [VW-1:0]                       near_div_w;
  logic [VW-1:0]                       nearf_w;
  logic [sfsc_pkg::PID_W-1:0]          apid_w;
  logic                                skip_w;
  logic                                at_full_w;
  logic                                done_now_w;

  // Result-cycle terms
  logic signed [SW-1:0]                volt_pre;
  logic signed [SW-1:0]                mv_s;
  logic signed [SW-1:0]                volt_c;
  logic signed [sfsc_pkg::OUT_V_W-1:0] volt15;
  logic [VW-1:0]                       avolt;
  logic                                ok_turn;
  logic                                ok_straight;
  logic                                settle_ok;
  logic                                out_free;
  logic                                in_accept;

  sfsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sfsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Rounded taper: (2*full*num + den) / (2*den)
  assign div_dividend = {1'b0, prod_r, 1'b0} + sfsc_pkg::DVD_W'(den_r);
  assign div_divisor  = {den_r, 1'b0};

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;

  // Floor decision, evaluated once per transaction from the captured transaction
  always_comb begin
    full_w      = VW'(cfg.feedforward * VW'(sfsc_pkg::FLOOR_SCALE));
    near_prod_w = NEAR_PROD_W'(cfg.feedforward) * NEAR_PROD_W'(NEAR_MUL);
    near_div_w  = VW'(near_prod_w >> NEAR_SH);
    nearf_w     = (cfg.near_min_volt > near_div_w) ? cfg.near_min_volt : near_div_w;
    apid_w      = pid_r[sfsc_pkg::PID_W-1] ? sfsc_pkg::PID_W'(-pid_r)
                                           : sfsc_pkg::PID_W'(pid_r);
    skip_w      = (full_w == '0)
               || (cfg.full_floor_err <= cfg.acceptable_err)
               || (aerr_r <= {1'b0, cfg.acceptable_err})
               || (apid_w >= sfsc_pkg::PID_W'(full_w));
    at_full_w   = aerr_r >= {1'b0, cfg.full_floor_err};
    done_now_w  = move_done_r
               || (settled_r >= cfg.settle_ticks)
               || (elapsed_r >= cfg.timeout_ticks);
  end

  // Drive command, clamp and settle test
  always_comb begin
    if (use_floor_r) begin
      volt_pre = err_neg_r ? -$signed({5'b0, applied_r}) : $signed({5'b0, applied_r});
    end else begin
      volt_pre = SW'(pid_r);
    end
    mv_s = $signed({5'b0, cfg.max_volt});
    if (volt_pre > mv_s) begin
      volt_c = mv_s;
    end else if (volt_pre < -mv_s) begin
      volt_c = -mv_s;
    end else begin
      volt_c = volt_pre;
    end
    volt15      = volt_c[sfsc_pkg::OUT_V_W-1:0];
    avolt       = volt_c[SW-1] ? VW'(-volt_c) : volt_c[VW-1:0];
    // Turn settles at a quarter of max, straight at 15 percent
    ok_turn     = {avolt, 2'b00} <= {2'b00, cfg.max_volt};
    ok_straight = (20'(avolt) * 20'd20) <= (20'(cfg.max_volt) * 20'd3);
    settle_ok   = (aerr_r <= {1'b0, cfg.acceptable_err})
               && (cfg.turn_mode ? ok_turn : ok_straight);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    case (state_r)
      sfsc_pkg::ST_IDLE: begin
        // Take nothing while reset is held
        in_ch.ready = rst_n;
        if (in_ch.valid) begin
          state_nxt = sfsc_pkg::ST_EVAL;
        end
      end
      sfsc_pkg::ST_EVAL: begin
        // Only a running tick in the taper region needs the divider
        if (action_r == sfsc_pkg::ACT_TICK && !done_now_w && !skip_w && !at_full_w) begin
          state_nxt = sfsc_pkg::ST_MUL;
        end else begin
          state_nxt = sfsc_pkg::ST_FIN;
        end
      end
      sfsc_pkg::ST_MUL: begin
        state_nxt = sfsc_pkg::ST_DSTART;
      end
      sfsc_pkg::ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = sfsc_pkg::ST_DIV;
      end
      sfsc_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = sfsc_pkg::ST_FIN;
        end
      end
      sfsc_pkg::ST_FIN: begin
        // Hold until the output register can take the result
        if (out_free) begin
          state_nxt = sfsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sfsc_pkg::ST_IDLE;
      end
    endcase
  end

  // Capture and floor datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      action_r  <= in_ch.action;
      pid_r     <= in_ch.pid_command;
      err_neg_r <= in_ch.error[sfsc_pkg::IN_ERR_W-1];
      aerr_r    <= in_ch.error[sfsc_pkg::IN_ERR_W-1] ? sfsc_pkg::IN_ERR_W'(-in_ch.error)
                                                     : sfsc_pkg::IN_ERR_W'(in_ch.error);
    end
    case (state_r)
      sfsc_pkg::ST_EVAL: begin
        use_floor_r <= !skip_w;
        applied_r   <= full_w;
        full_r      <= full_w;
        nearf_r     <= nearf_w;
        num_r       <= sfsc_pkg::ERR_W'(aerr_r - {1'b0, cfg.acceptable_err});
        den_r       <= cfg.full_floor_err - cfg.acceptable_err;
      end
      sfsc_pkg::ST_MUL: begin
        prod_r <= full_r * num_r;
      end
      sfsc_pkg::ST_DIV: begin
        // Tapered floor never drops below the near floor
        if (div_done) begin
          applied_r <= (nearf_r > div_q) ? nearf_r : div_q;
        end
      end
      default: ;
    endcase
  end

  // Move state: end check on evaluation, counters advance when the result loads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= '0;
      settled_r   <= '0;
      move_done_r <= 1'b1;
      reason_r    <= sfsc_pkg::REASON_RUNNING;
    end else if (state_r == sfsc_pkg::ST_EVAL) begin
      if (action_r == sfsc_pkg::ACT_START) begin
        elapsed_r   <= '0;
        settled_r   <= '0;
        move_done_r <= 1'b0;
        reason_r    <= sfsc_pkg::REASON_RUNNING;
      end else if (!move_done_r) begin
        // Settling takes precedence over timeout
        if (settled_r >= cfg.settle_ticks) begin
          move_done_r <= 1'b1;
          reason_r    <= sfsc_pkg::REASON_SETTLED;
        end else if (elapsed_r >= cfg.timeout_ticks) begin
          move_done_r <= 1'b1;
          reason_r    <= sfsc_pkg::REASON_TIMEOUT;
        end
      end
    end else if (state_r == sfsc_pkg::ST_FIN && out_free
                 && action_r == sfsc_pkg::ACT_TICK && !move_done_r) begin
      settled_r <= settle_ok ? settled_r + 1'b1 : '0;
      elapsed_r <= elapsed_r + 1'b1;
    end
  end

  // Output register: valid is control, payload loads with it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sfsc_pkg::ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sfsc_pkg::ST_FIN && out_free) begin
      if (action_r == sfsc_pkg::ACT_START) begin
        left_r       <= '0;
        right_r      <= '0;
        finished_r   <= 1'b0;
        end_reason_r <= sfsc_pkg::REASON_RUNNING;
      end else if (move_done_r) begin
        // Brake: zero drive, report why the move ended
        left_r       <= '0;
        right_r      <= '0;
        finished_r   <= 1'b1;
        end_reason_r <= reason_r;
      end else begin
        left_r       <= cfg.turn_mode ? -volt15 : volt15;
        right_r      <= volt15;
        finished_r   <= 1'b0;
        end_reason_r <= sfsc_pkg::REASON_RUNNING;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.left_volt  = left_r;
  assign out_ch.right_volt = right_r;
  assign out_ch.finished   = finished_r;
  assign out_ch.end_reason = end_reason_r;

  // A transaction occupies the block: no second one in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ch.ready)
    else $error("input accepted back to back");

  // A finished move drives no voltage
  a_finished_brakes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.finished) |-> (out_ch.left_volt == '0 && out_ch.right_volt == '0))
    else $error("finished result carries drive");

  // An end reason is only reported on a finished move
  a_reason_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.end_reason != sfsc_pkg::REASON_RUNNING) |-> out_ch.finished)
    else $error("end reason without finished");

  // Only a start transaction reopens a move
  a_reopen_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(move_done_r) |-> $past(state_r == sfsc_pkg::ST_EVAL && action_r == sfsc_pkg::ACT_START))
    else $error("move reopened without start");

endmodule

// ===== hdl/sfsc_cfg.sv =====
module sfsc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sfsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfsc_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  output sfsc_pkg::cfg_t                     cfg
);

  sfsc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_volt       <= sfsc_pkg::MAX_VOLT_RST;
      cfg_r.feedforward    <= '0;
      cfg_r.acceptable_err <= '0;
      cfg_r.full_floor_err <= '0;
      cfg_r.near_min_volt  <= '0;
      cfg_r.turn_mode      <= 1'b0;
      cfg_r.timeout_ticks  <= '0;
      cfg_r.settle_ticks   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfsc_pkg::REG_MAX_VOLT:    cfg_r.max_volt       <= cfg_wdata[sfsc_pkg::VOLT_W-1:0];
        sfsc_pkg::REG_FEEDFORWARD: cfg_r.feedforward    <= cfg_wdata[sfsc_pkg::FF_W-1:0];
        sfsc_pkg::REG_ACCEPTABLE:  cfg_r.acceptable_err <= cfg_wdata[sfsc_pkg::ERR_W-1:0];
        sfsc_pkg::REG_FULL_FLOOR:  cfg_r.full_floor_err <= cfg_wdata[sfsc_pkg::ERR_W-1:0];
        sfsc_pkg::REG_NEAR_MIN:    cfg_r.near_min_volt  <= cfg_wdata[sfsc_pkg::VOLT_W-1:0];
        sfsc_pkg::REG_TURN_MODE:   cfg_r.turn_mode      <= cfg_wdata[0];
        sfsc_pkg::REG_TIMEOUT:     cfg_r.timeout_ticks  <= cfg_wdata[sfsc_pkg::TICK_W-1:0];
        sfsc_pkg::REG_SETTLE:      cfg_r.settle_ticks   <= cfg_wdata[sfsc_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/sfsc_div.sv =====
module sfsc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sfsc_pkg::DVD_W-1:0]     dividend,
  input  logic [sfsc_pkg::DVS_W-1:0]     divisor,
  output logic                           done,
  output logic [sfsc_pkg::QUO_W-1:0]     quotient
);

  // Restoring division, one quotient bit per cycle, MSB first.
  // Caller guarantees the quotient fits in QUO_W bits.
  logic [sfsc_pkg::DVD_W-1:0]  rem_r, rem_nxt;
  logic [sfsc_pkg::DVD_W-1:0]  dsh_r, dsh_nxt;
  logic [sfsc_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic [sfsc_pkg::DCNT_W-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic                        fits;

  always_comb begin
    fits    = rem_r >= dsh_r;
    rem_nxt = fits ? rem_r - dsh_r : rem_r;
    quo_nxt = {quo_r[sfsc_pkg::QUO_W-2:0], fits};
    dsh_nxt = dsh_r >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= sfsc_pkg::DCNT_W'(sfsc_pkg::QUO_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= sfsc_pkg::DVD_W'({divisor, {(sfsc_pkg::QUO_W-1){1'b0}}});
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dsh_r <= dsh_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
